// ----- design/ati_pkg.sv -----
// shared constants of the affine transform inverse block
// register map, status codes and the cofactor operand table; no dependencies
`default_nettype none

package ati_pkg;

  localparam int unsigned THR_WIDTH      = 31;
  localparam int unsigned CFG_DATA_WIDTH = 32;
  localparam int unsigned CFG_ADDR_WIDTH = 3;

  // register select bit of the byte address and the register index on it
  localparam int unsigned REG_SEL_BIT       = 2;
  localparam logic        REG_DET_THRESHOLD = 1'b0;

  localparam logic [THR_WIDTH-1:0] THR_RESET = 31'd1;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_SINGULAR = 1'b1;

  localparam logic [1:0] FIRST_ROW = 2'd0;
  localparam logic [1:0] LAST_ROW  = 2'd2;

  localparam int unsigned NUM_ROWS = 3;
  localparam int unsigned NUM_PROD = 6;
  localparam int unsigned NUM_MAT  = 9;

  // per row: six product operand pairs (a, b) over the matrix words
  // adjugate entry j of the row is product 2j minus product 2j+1
  localparam logic [3:0] ROW_OPS [NUM_ROWS][2*NUM_PROD] = '{
    '{4'd4, 4'd8, 4'd7, 4'd5, 4'd7, 4'd2, 4'd1, 4'd8, 4'd1, 4'd5, 4'd4, 4'd2},
    '{4'd6, 4'd5, 4'd3, 4'd8, 4'd0, 4'd8, 4'd6, 4'd2, 4'd3, 4'd2, 4'd0, 4'd5},
    '{4'd3, 4'd7, 4'd6, 4'd4, 4'd6, 4'd1, 4'd0, 4'd7, 4'd0, 4'd4, 4'd3, 4'd1}
  };

endpackage

`default_nettype wire

// ----- design/ati_div_lane.sv -----
// pipelined restoring divider lane, one quotient bit per stage
// rounds half away from zero and saturates to a signed word; no package use
`default_nettype none

module ati_div_lane #(
  parameter int unsigned WORD_WIDTH = 32,
  parameter int unsigned NUM_WIDTH  = 115,
  parameter int unsigned DEN_WIDTH  = 99
) (
  input  logic                  clk_i,
  input  logic [WORD_WIDTH+2:0] en_i,
  input  logic [NUM_WIDTH-1:0]  num_i,
  input  logic [DEN_WIDTH-1:0]  den_i,
  input  logic                  neg_i,
  output logic [WORD_WIDTH-1:0] quo_o
);

  localparam int unsigned W   = WORD_WIDTH;
  localparam int unsigned NB  = W + 1;
  localparam int unsigned NB1 = NB + 1;
  localparam int unsigned RW  = (NUM_WIDTH > DEN_WIDTH + NB) ? NUM_WIDTH : DEN_WIDTH + NB;

  localparam logic [NB:0]  LIM     = NB1'(1) << (W - 1);
  localparam logic [W-1:0] SAT_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] SAT_MIN = {1'b1, {(W-1){1'b0}}};

  logic [RW-1:0]        rem_q [NB+1];
  logic [DEN_WIDTH-1:0] den_q [NB+1];
  logic [NB-1:0]        quo_q [NB+1];
  logic                 big_q [NB+1];
  logic                 neg_q [NB+1];
  logic [W-1:0]         res_q;

  // quotient of 2^(W+1) or more always saturates
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      rem_q[0] <= RW'(num_i);
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      big_q[0] <= RW'(num_i) >= (RW'(den_i) << NB);
      neg_q[0] <= neg_i;
    end
  end

  for (genvar s = 1; s <= NB; s++) begin : g_step
    localparam int unsigned K = NB - s;
    logic [RW-1:0] dsh;
    logic [RW:0]   diff;

    assign dsh  = RW'(den_q[s-1]) << K;
    assign diff = {1'b0, rem_q[s-1]} - {1'b0, dsh};

    always_ff @(posedge clk_i) begin
      if (en_i[s]) begin
        rem_q[s] <= diff[RW] ? rem_q[s-1] : diff[RW-1:0];
        quo_q[s] <= {quo_q[s-1][NB-2:0], ~diff[RW]};
        den_q[s] <= den_q[s-1];
        big_q[s] <= big_q[s-1];
        neg_q[s] <= neg_q[s-1];
      end
    end
  end

  logic         rnd_up;
  logic [NB:0]  qr;
  logic [W-1:0] res_d;

  assign rnd_up = {rem_q[NB], 1'b0} >= {1'b0, RW'(den_q[NB])};
  assign qr     = {1'b0, quo_q[NB]} + NB1'(rnd_up);

  always_comb begin
    if (!neg_q[NB]) begin
      res_d = (big_q[NB] || qr >= LIM) ? SAT_MAX : qr[W-1:0];
    end else begin
      res_d = (big_q[NB] || qr > LIM) ? SAT_MIN : W'(0) - qr[W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[NB+1]) begin
      res_q <= res_d;
    end
  end

  assign quo_o = res_q;

endmodule

`default_nettype wire

// ----- design/affine_transform_inverse.sv -----
// Inverse of a 3x4 affine transform in signed fixed point. One transform is taken on the
// input channel and gives three row beats (rows 0, 1, 2) on the result channel; the block
// takes the next transform as the last row of the current one issues, when the result side
// does not stall. Eight stages form the adjugate row, determinant and translation
// numerator, then four divider lanes of WORD_WIDTH+3 stages resolve one quotient bit per
// stage, and one output register follows. det_threshold is written over the APB port at
// byte address 0; the user must write it only while the block is idle, which the block
// itself does not enforce.
// depends on ati_pkg and ati_div_lane
`default_nettype none

module affine_transform_inverse
  import ati_pkg::*;
#(
  parameter int unsigned WORD_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,

  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [CFG_ADDR_WIDTH-1:0]     paddr,
  input  logic [CFG_DATA_WIDTH-1:0]     pwdata,
  output logic [CFG_DATA_WIDTH-1:0]     prdata,
  output logic                          pready,

  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [WORD_WIDTH-1:0]  m00_i,
  input  logic signed [WORD_WIDTH-1:0]  m01_i,
  input  logic signed [WORD_WIDTH-1:0]  m02_i,
  input  logic signed [WORD_WIDTH-1:0]  m10_i,
  input  logic signed [WORD_WIDTH-1:0]  m11_i,
  input  logic signed [WORD_WIDTH-1:0]  m12_i,
  input  logic signed [WORD_WIDTH-1:0]  m20_i,
  input  logic signed [WORD_WIDTH-1:0]  m21_i,
  input  logic signed [WORD_WIDTH-1:0]  m22_i,
  input  logic signed [WORD_WIDTH-1:0]  trans_x_i,
  input  logic signed [WORD_WIDTH-1:0]  trans_y_i,
  input  logic signed [WORD_WIDTH-1:0]  trans_z_i,

  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    row_index_o,
  output logic signed [WORD_WIDTH-1:0]  out_c0_o,
  output logic signed [WORD_WIDTH-1:0]  out_c1_o,
  output logic signed [WORD_WIDTH-1:0]  out_c2_o,
  output logic signed [WORD_WIDTH-1:0]  out_trans_o,
  output logic signed [WORD_WIDTH-1:0]  scale_w_o,
  output logic                          status_o,
  output logic                          last_o
);

  localparam int unsigned W    = WORD_WIDTH;
  localparam int unsigned F    = FRAC_BITS;
  localparam int unsigned PW   = 2 * W;
  localparam int unsigned CW   = 2 * W + 1;
  localparam int unsigned XW   = 2 * W + 1;
  localparam int unsigned SW   = 3 * W + 1;
  localparam int unsigned DW   = 3 * W + 3;
  localparam int unsigned DW1  = DW + 1;
  localparam int unsigned NW   = (CW + 2 * F > DW + F) ? CW + 2 * F : DW + F;
  localparam int unsigned TW   = (DW > THR_WIDTH + 2 * F) ? DW : THR_WIDTH + 2 * F;
  localparam int unsigned L    = W + 3;
  localparam int unsigned LB   = 8;
  localparam int unsigned NST  = LB + L + 1;
  localparam int unsigned NL   = 4;

  localparam logic [DW:0]  SAT_LIM   = DW1'(1) << (W - 1);
  localparam logic [W-1:0] SAT_MAX   = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] SAT_MIN   = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] SCALE_ONE = (F >= W - 1) ? SAT_MAX : (W'(1) << F);

  function automatic logic [W-1:0] sat_mag(input logic [DW:0] mag, input logic neg);
    logic [W-1:0] res;
    if (!neg) begin
      res = (mag >= SAT_LIM) ? SAT_MAX : mag[W-1:0];
    end else begin
      res = (mag > SAT_LIM) ? SAT_MIN : W'(0) - mag[W-1:0];
    end
    return res;
  endfunction

  function automatic logic [W-1:0] rsat(input logic [DW-1:0] mag, input logic neg,
                                        input int unsigned sh);
    logic [DW:0] half;
    logic [DW:0] rnd;
    half = DW1'(1) << (sh - 1);
    rnd  = ({1'b0, mag} + half) >> sh;
    return sat_mag(rnd, neg);
  endfunction

  // configuration
  logic [THR_WIDTH-1:0] thr_q;
  logic                 cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (cfg_wr && paddr[REG_SEL_BIT] == REG_DET_THRESHOLD) begin
      thr_q <= pwdata[THR_WIDTH-1:0];
    end
  end

  assign prdata = (paddr[REG_SEL_BIT] == REG_DET_THRESHOLD) ?
                  CFG_DATA_WIDTH'(thr_q) : '0;

  // stage advance: a stage loads when it or any later stage has a hole or the output drains
  logic [NST-1:0] v_q;
  logic [NST-1:0] adv;

  for (genvar k = 0; k < NST; k++) begin : g_adv
    assign adv[k] = out_ready_i || !(&v_q[NST-1:k]);
  end

  // input holding register and row sequencer
  logic                hold_v_q;
  logic [1:0]          row_q;
  logic signed [W-1:0] hm_q [NUM_MAT];
  logic signed [W-1:0] ht_q [3];
  logic                accept_in;
  logic                issue;

  assign in_ready_o = !hold_v_q || (adv[0] && row_q == LAST_ROW);
  assign accept_in  = in_valid_i && in_ready_o;
  assign issue      = hold_v_q && adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_v_q <= 1'b0;
      row_q    <= FIRST_ROW;
    end else if (accept_in) begin
      hold_v_q <= 1'b1;
      row_q    <= FIRST_ROW;
    end else if (issue) begin
      row_q <= row_q + 2'd1;
      if (row_q == LAST_ROW) begin
        hold_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      hm_q[0] <= m00_i;
      hm_q[1] <= m01_i;
      hm_q[2] <= m02_i;
      hm_q[3] <= m10_i;
      hm_q[4] <= m11_i;
      hm_q[5] <= m12_i;
      hm_q[6] <= m20_i;
      hm_q[7] <= m21_i;
      hm_q[8] <= m22_i;
      ht_q[0] <= trans_x_i;
      ht_q[1] <= trans_y_i;
      ht_q[2] <= trans_z_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) begin
        v_q[0] <= hold_v_q;
      end
      for (int k = 1; k < NST; k++) begin
        if (adv[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // stage 0: operand selection for the current row
  logic signed [W-1:0] opa_d [NUM_PROD];
  logic signed [W-1:0] opb_d [NUM_PROD];
  logic signed [W-1:0] mcol_d [3];

  always_comb begin
    for (int p = 0; p < NUM_PROD; p++) begin
      opa_d[p] = hm_q[ROW_OPS[row_q][2*p]];
      opb_d[p] = hm_q[ROW_OPS[row_q][2*p+1]];
    end
    for (int j = 0; j < 3; j++) begin
      mcol_d[j] = hm_q[4'(3 * j) + {2'b00, row_q}];
    end
  end

  logic signed [W-1:0] s0_a_q [NUM_PROD];
  logic signed [W-1:0] s0_b_q [NUM_PROD];
  logic signed [W-1:0] s0_mc_q [3];
  logic signed [W-1:0] s0_t_q [3];
  logic [1:0]          s0_row_q;

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      s0_a_q   <= opa_d;
      s0_b_q   <= opb_d;
      s0_mc_q  <= mcol_d;
      s0_t_q   <= ht_q;
      s0_row_q <= row_q;
    end
  end

  // stage 1: minor products
  logic signed [PW-1:0] s1_p_q [NUM_PROD];
  logic signed [W-1:0]  s1_mc_q [3];
  logic signed [W-1:0]  s1_t_q [3];
  logic [1:0]           s1_row_q;

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      for (int p = 0; p < NUM_PROD; p++) begin
        s1_p_q[p] <= s0_a_q[p] * s0_b_q[p];
      end
      s1_mc_q  <= s0_mc_q;
      s1_t_q   <= s0_t_q;
      s1_row_q <= s0_row_q;
    end
  end

  // stage 2: adjugate row
  logic signed [CW-1:0] s2_c_q [3];
  logic signed [W-1:0]  s2_mc_q [3];
  logic signed [W-1:0]  s2_t_q [3];
  logic [1:0]           s2_row_q;

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      for (int j = 0; j < 3; j++) begin
        s2_c_q[j] <= s1_p_q[2*j] - s1_p_q[2*j+1];
      end
      s2_mc_q  <= s1_mc_q;
      s2_t_q   <= s1_t_q;
      s2_row_q <= s1_row_q;
    end
  end

  // stage 3: split products of the adjugate with the matrix column and translation
  logic signed [W:0]    c_lo [3];
  logic signed [W:0]    c_hi [3];
  logic signed [XW-1:0] s3_dl_q [3];
  logic signed [XW-1:0] s3_dh_q [3];
  logic signed [XW-1:0] s3_tl_q [3];
  logic signed [XW-1:0] s3_th_q [3];
  logic signed [CW-1:0] s3_c_q [3];
  logic [1:0]           s3_row_q;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      c_lo[j] = $signed({1'b0, s2_c_q[j][W-1:0]});
      c_hi[j] = $signed(s2_c_q[j][CW-1:W]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      for (int j = 0; j < 3; j++) begin
        s3_dl_q[j] <= s2_mc_q[j] * c_lo[j];
        s3_dh_q[j] <= s2_mc_q[j] * c_hi[j];
        s3_tl_q[j] <= s2_t_q[j] * c_lo[j];
        s3_th_q[j] <= s2_t_q[j] * c_hi[j];
      end
      s3_c_q   <= s2_c_q;
      s3_row_q <= s2_row_q;
    end
  end

  // stage 4: join partial products
  logic signed [SW-1:0] s4_dp_q [3];
  logic signed [SW-1:0] s4_tp_q [3];
  logic signed [CW-1:0] s4_c_q [3];
  logic [1:0]           s4_row_q;

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      for (int j = 0; j < 3; j++) begin
        s4_dp_q[j] <= (SW'(s3_dh_q[j]) <<< W) + SW'(s3_dl_q[j]);
        s4_tp_q[j] <= (SW'(s3_th_q[j]) <<< W) + SW'(s3_tl_q[j]);
      end
      s4_c_q   <= s3_c_q;
      s4_row_q <= s3_row_q;
    end
  end

  // stage 5: determinant and translation numerator
  logic signed [DW-1:0] s5_det_q;
  logic signed [DW-1:0] s5_tn_q;
  logic signed [CW-1:0] s5_c_q [3];
  logic [1:0]           s5_row_q;

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      s5_det_q <= DW'(s4_dp_q[0]) + DW'(s4_dp_q[1]) + DW'(s4_dp_q[2]);
      s5_tn_q  <= DW'(0) - (DW'(s4_tp_q[0]) + DW'(s4_tp_q[1]) + DW'(s4_tp_q[2]));
      s5_c_q   <= s4_c_q;
      s5_row_q <= s4_row_q;
    end
  end

  // stage 6: magnitudes and signs
  logic [DW-1:0] s6_dmag_q;
  logic          s6_dneg_q;
  logic [DW-1:0] s6_tmag_q;
  logic          s6_tneg_q;
  logic [CW-1:0] s6_cmag_q [3];
  logic          s6_cneg_q [3];
  logic [1:0]    s6_row_q;

  always_ff @(posedge clk_i) begin
    if (adv[6]) begin
      s6_dmag_q <= s5_det_q[DW-1] ? DW'(-s5_det_q) : DW'(s5_det_q);
      s6_dneg_q <= s5_det_q[DW-1];
      s6_tmag_q <= s5_tn_q[DW-1] ? DW'(-s5_tn_q) : DW'(s5_tn_q);
      s6_tneg_q <= s5_tn_q[DW-1];
      for (int j = 0; j < 3; j++) begin
        s6_cmag_q[j] <= s5_c_q[j][CW-1] ? CW'(-s5_c_q[j]) : CW'(s5_c_q[j]);
        s6_cneg_q[j] <= s5_c_q[j][CW-1];
      end
      s6_row_q <= s5_row_q;
    end
  end

  // stage 7: threshold test, divider operands, singular results
  logic          ok_d;
  logic [NW-1:0] s7_num_q [NL];
  logic          s7_neg_q [NL];
  logic [DW-1:0] s7_den_q;
  logic [W-1:0]  s7_alt_q [NL];
  logic [W-1:0]  s7_scale_q;
  logic          s7_ok_q;
  logic [1:0]    s7_row_q;

  assign ok_d = TW'(s6_dmag_q) > (TW'(thr_q) << (2 * F));

  always_ff @(posedge clk_i) begin
    if (adv[7]) begin
      for (int j = 0; j < 3; j++) begin
        s7_num_q[j] <= NW'(s6_cmag_q[j]) << (2 * F);
        s7_neg_q[j] <= s6_cneg_q[j] ^ s6_dneg_q;
        s7_alt_q[j] <= rsat(DW'(s6_cmag_q[j]), s6_cneg_q[j], F);
      end
      s7_num_q[3] <= NW'(s6_tmag_q) << F;
      s7_neg_q[3] <= s6_tneg_q ^ s6_dneg_q;
      s7_alt_q[3] <= rsat(s6_tmag_q, s6_tneg_q, 2 * F);
      s7_den_q    <= s6_dmag_q;
      s7_scale_q  <= ok_d ? SCALE_ONE : rsat(s6_dmag_q, s6_dneg_q, 2 * F);
      s7_ok_q     <= ok_d;
      s7_row_q    <= s6_row_q;
    end
  end

  // divider lanes: three matrix columns and the translation
  logic [W-1:0] lane_quo [NL];

  for (genvar q = 0; q < NL; q++) begin : g_lane
    ati_div_lane #(
      .WORD_WIDTH (W),
      .NUM_WIDTH  (NW),
      .DEN_WIDTH  (DW)
    ) u_lane (
      .clk_i (clk_i),
      .en_i  (adv[LB+L-1:LB]),
      .num_i (s7_num_q[q]),
      .den_i (s7_den_q),
      .neg_i (s7_neg_q[q]),
      .quo_o (lane_quo[q])
    );
  end

  // sideband alongside the lanes
  logic [W-1:0] sb_alt_q [L][NL];
  logic [W-1:0] sb_scale_q [L];
  logic         sb_ok_q [L];
  logic [1:0]   sb_row_q [L];

  always_ff @(posedge clk_i) begin
    if (adv[LB]) begin
      sb_alt_q[0]   <= s7_alt_q;
      sb_scale_q[0] <= s7_scale_q;
      sb_ok_q[0]    <= s7_ok_q;
      sb_row_q[0]   <= s7_row_q;
    end
    for (int s = 1; s < L; s++) begin
      if (adv[LB+s]) begin
        sb_alt_q[s]   <= sb_alt_q[s-1];
        sb_scale_q[s] <= sb_scale_q[s-1];
        sb_ok_q[s]    <= sb_ok_q[s-1];
        sb_row_q[s]   <= sb_row_q[s-1];
      end
    end
  end

  // output register
  logic [1:0]          row_index_q;
  logic signed [W-1:0] out_c_q [3];
  logic signed [W-1:0] out_trans_q;
  logic signed [W-1:0] scale_w_q;
  logic                status_q;
  logic                last_q;

  always_ff @(posedge clk_i) begin
    if (adv[NST-1]) begin
      for (int j = 0; j < 3; j++) begin
        out_c_q[j] <= sb_ok_q[L-1] ? lane_quo[j] : sb_alt_q[L-1][j];
      end
      out_trans_q <= sb_ok_q[L-1] ? lane_quo[3] : sb_alt_q[L-1][3];
      scale_w_q   <= sb_scale_q[L-1];
      status_q    <= sb_ok_q[L-1] ? STATUS_OK : STATUS_SINGULAR;
      row_index_q <= sb_row_q[L-1];
      last_q      <= sb_row_q[L-1] == LAST_ROW;
    end
  end

  assign out_valid_o = v_q[NST-1];
  assign row_index_o = row_index_q;
  assign out_c0_o    = out_c_q[0];
  assign out_c1_o    = out_c_q[1];
  assign out_c2_o    = out_c_q[2];
  assign out_trans_o = out_trans_q;
  assign scale_w_o   = scale_w_q;
  assign status_o    = status_q;
  assign last_o      = last_q;

  // checks
  a_accept_restarts_rows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (hold_v_q && row_q == FIRST_ROW))
    else $error("accepted transform did not restart the row sequence");

  a_stall_holds_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hold_v_q && !adv[0] && !in_valid_i) |=> $stable(row_q))
    else $error("row sequencer moved while the pipeline was stalled");

  a_ok_scale_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == STATUS_OK) |-> (scale_w_o == SCALE_ONE))
    else $error("inverse beat without unit scale");

endmodule

`default_nettype wire
